[rtl/fpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Codes and rounding helper shared by the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam logic [1:0] FUNC_ADD = 2'd0;
   localparam logic [1:0] FUNC_SUB = 2'd1;
   localparam logic [1:0] FUNC_MUL = 2'd2;
   localparam logic [1:0] FUNC_DIV = 2'd3;

   localparam logic [1:0] RND_ZERO = 2'd0;
   localparam logic [1:0] RND_EVEN = 2'd1;
   localparam logic [1:0] RND_POS  = 2'd2;
   localparam logic [1:0] RND_NEG  = 2'd3;

   localparam logic [1:0] REG_INT_BITS   = 2'd0;
   localparam logic [1:0] REG_FRAC_BITS  = 2'd1;
   localparam logic [1:0] REG_ROUND_MODE = 2'd2;

   localparam int CSR_ADDR_W = 4;

   // Magnitude quotient increment. gt/eq compare twice the remainder with the divisor.
   function automatic logic round_up(input logic nz, input logic gt, input logic eq,
                                     input logic q0, input logic neg, input logic [1:0] mode);
      logic up;
      unique case (mode)
         RND_ZERO: up = 1'b0;
         RND_EVEN: up = nz & (gt | (eq & q0));
         RND_POS:  up = nz & ~neg;
         RND_NEG:  up = nz & neg;
         default:  up = 1'b0;
      endcase
      return up;
   endfunction

endpackage

[rtl/fixed_point_alu_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_core
// Pipelined signed fixed-point add, subtract, multiply and divide.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per operation (func, operand_a, operand_b); rsp_*
//   returns one beat (result, zero_div) per request, in order.
//   csr_* is an APB-style port: int_bits at 0x0, frac_bits at 0x4,
//   round_mode at 0x8. Write it only while no beat is in flight.
//   Every func takes the same path: decode, magnitude, multiply, product
//   round, then one restoring divide step per stage over the
//   2*MAX_WIDTH-bit dividend, then the final round and sign extend into
//   the output register.
//   Throughput is one beat per cycle while rsp_stall does not hold the pipeline.
//   Reset clears all stage valids and loads the format 16.16, round to zero.
//   When rsp_stall is high with a beat waiting, the whole pipeline holds and
//   req_stall rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module fixed_point_alu_core
   import fpa_pkg::*;
#(
   parameter int MAX_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_func,
   input  logic [31:0]           req_operand_a,
   input  logic [31:0]           req_operand_b,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [31:0]    rsp_result,
   output logic                  rsp_zero_div,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int MW = MAX_WIDTH;
   localparam int NW = 2 * MW;
   localparam logic [6:0] MW7 = 7'(MW);
   localparam int RST_INT  = (16 > MW) ? MW : 16;
   localparam int RST_FRAC = (RST_INT + 16 > MW) ? MW - RST_INT : 16;

   typedef struct packed {
      logic [1:0]    func;
      logic          neg;
      logic          dz;
      logic [MW-1:0] d;
      logic [NW-1:0] n;
      logic [MW-1:0] rem;
      logic [MW-1:0] q;
      logic [MW-1:0] res;
   } dstage_type;

   // configuration
   logic [5:0] int_bits_ff, int_bits_in;
   logic [4:0] frac_bits_ff, frac_bits_in;
   logic [1:0] round_mode_ff, round_mode_in;
   logic       csr_wr;
   logic [1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_comb begin
      logic [6:0] iv;
      logic [6:0] fv;
      iv = {1'b0, int_bits_ff};
      fv = {2'b0, frac_bits_ff};
      round_mode_in = round_mode_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_INT_BITS: begin
               iv = {1'b0, csr_pwdata[5:0]};
               if (iv == 7'd0) iv = 7'd1;
               if (iv > MW7) iv = MW7;
            end
            REG_FRAC_BITS: begin
               fv = {2'b0, csr_pwdata[4:0]};
            end
            REG_ROUND_MODE: begin
               round_mode_in = csr_pwdata[1:0];
            end
            default: begin
            end
         endcase
         if (iv + fv > MW7) fv = MW7 - iv;
      end
      int_bits_in  = iv[5:0];
      frac_bits_in = fv[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_bits_ff   <= 6'(RST_INT);
         frac_bits_ff  <= 5'(RST_FRAC);
         round_mode_ff <= RND_ZERO;
      end else begin
         int_bits_ff   <= int_bits_in;
         frac_bits_ff  <= frac_bits_in;
         round_mode_ff <= round_mode_in;
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_INT_BITS:   csr_prdata = {26'd0, int_bits_ff};
         REG_FRAC_BITS:  csr_prdata = {27'd0, frac_bits_ff};
         REG_ROUND_MODE: csr_prdata = {30'd0, round_mode_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   // format masks
   logic [6:0]    tot_w;
   logic [MW-1:0] mask_mw;
   logic [MW-1:0] sign_mw;
   logic [31:0]   mask32;

   assign tot_w   = {1'b0, int_bits_ff} + {2'b0, frac_bits_ff};
   assign mask_mw = {MW{1'b1}} >> (MW7 - tot_w);
   assign sign_mw = mask_mw ^ (mask_mw >> 1);
   assign mask32  = 32'(mask_mw);

   // pipeline control
   logic en;
   assign en        = ~(rsp_valid & rsp_stall);
   assign req_stall = rsp_valid & rsp_stall;

   // stage A: masked operands
   logic          a_vld_ff;
   logic [1:0]    a_func_ff;
   logic [MW-1:0] a_opa_ff, a_opb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_func_ff <= req_func;
         a_opa_ff  <= req_operand_a[MW-1:0] & mask_mw;
         a_opb_ff  <= req_operand_b[MW-1:0] & mask_mw;
      end
   end

   // stage B: magnitudes, add/sub
   logic          b_vld_ff;
   logic [1:0]    b_func_ff;
   logic          b_neg_ff, b_dz_ff;
   logic [MW-1:0] b_amag_ff, b_bmag_ff, b_res_ff;
   logic          a_an, a_bn;

   assign a_an = |(a_opa_ff & sign_mw);
   assign a_bn = |(a_opb_ff & sign_mw);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_func_ff <= a_func_ff;
         b_neg_ff  <= a_an ^ a_bn;
         b_dz_ff   <= (a_func_ff == FUNC_DIV) && (a_opb_ff == '0);
         b_amag_ff <= a_an ? ((MW'(0) - a_opa_ff) & mask_mw) : a_opa_ff;
         b_bmag_ff <= a_bn ? ((MW'(0) - a_opb_ff) & mask_mw) : a_opb_ff;
         b_res_ff  <= (a_func_ff == FUNC_SUB) ? a_opa_ff - a_opb_ff : a_opa_ff + a_opb_ff;
      end
   end

   // stage C: product and scaled dividend
   logic          c_vld_ff;
   logic [1:0]    c_func_ff;
   logic          c_neg_ff, c_dz_ff;
   logic [MW-1:0] c_d_ff, c_res_ff;
   logic [NW-1:0] c_prod_ff, c_n_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_func_ff <= b_func_ff;
         c_neg_ff  <= b_neg_ff;
         c_dz_ff   <= b_dz_ff;
         c_d_ff    <= b_bmag_ff;
         c_res_ff  <= b_res_ff;
         c_prod_ff <= NW'(b_amag_ff) * NW'(b_bmag_ff);
         c_n_ff    <= NW'(b_amag_ff) << frac_bits_ff;
      end
   end

   // stage D: product shift and round decision
   logic          d_vld_ff;
   logic [1:0]    d_func_ff;
   logic          d_neg_ff, d_dz_ff, d_up_ff;
   logic [MW-1:0] d_d_ff, d_res_ff, d_mq_ff;
   logic [NW-1:0] d_n_ff;
   logic [NW-1:0] c_qfull;
   logic [MW-1:0] c_pow, c_rem;
   logic [MW:0]   c_rem2;
   logic          c_up;

   assign c_qfull = c_prod_ff >> frac_bits_ff;
   assign c_pow   = MW'(1) << frac_bits_ff;
   assign c_rem   = c_prod_ff[MW-1:0] & (c_pow - MW'(1));
   assign c_rem2  = {c_rem, 1'b0};
   assign c_up    = round_up(c_rem != '0, c_rem2 > {1'b0, c_pow}, c_rem2 == {1'b0, c_pow},
                             c_qfull[0], c_neg_ff, round_mode_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_func_ff <= c_func_ff;
         d_neg_ff  <= c_neg_ff;
         d_dz_ff   <= c_dz_ff;
         d_d_ff    <= c_d_ff;
         d_res_ff  <= c_res_ff;
         d_n_ff    <= c_n_ff;
         d_mq_ff   <= c_qfull[MW-1:0];
         d_up_ff   <= c_up;
      end
   end

   // divider chain: entry 0 gets the product or add/sub result, then one step per stage
   logic [NW:0] dv_vld_ff;
   dstage_type  dv_ff [0:NW];
   logic [MW-1:0] d_mval, d_mres;

   assign d_mval = d_mq_ff + MW'(d_up_ff);
   assign d_mres = d_neg_ff ? MW'(0) - d_mval : d_mval;

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff <= '0;
      end else if (en) begin
         dv_vld_ff <= {dv_vld_ff[NW-1:0], d_vld_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff[0].func <= d_func_ff;
         dv_ff[0].neg  <= d_neg_ff;
         dv_ff[0].dz   <= d_dz_ff;
         dv_ff[0].d    <= d_d_ff;
         dv_ff[0].n    <= d_n_ff;
         dv_ff[0].rem  <= '0;
         dv_ff[0].q    <= '0;
         dv_ff[0].res  <= (d_func_ff == FUNC_MUL) ? d_mres : d_res_ff;
      end
   end

   for (genvar k = 1; k <= NW; k++) begin : g_div
      logic [MW:0] trial;
      logic        ge;
      dstage_type  nxt;

      assign trial = {dv_ff[k-1].rem, dv_ff[k-1].n[NW-1]};
      assign ge    = trial >= {1'b0, dv_ff[k-1].d};

      always_comb begin
         nxt     = dv_ff[k-1];
         nxt.n   = dv_ff[k-1].n << 1;
         nxt.rem = ge ? MW'(trial - {1'b0, dv_ff[k-1].d}) : trial[MW-1:0];
         nxt.q   = {dv_ff[k-1].q[MW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[k] <= nxt;
         end
      end
   end

   // final round, select, wrap and sign extend
   dstage_type    fin;
   logic [MW:0]   f_rem2;
   logic          f_up;
   logic [MW-1:0] f_qv, f_dres, f_val;
   logic          f_sbit;
   logic [31:0]   f_out;

   assign fin    = dv_ff[NW];
   assign f_rem2 = {fin.rem, 1'b0};
   assign f_up   = round_up(fin.rem != '0, f_rem2 > {1'b0, fin.d}, f_rem2 == {1'b0, fin.d},
                            fin.q[0], fin.neg, round_mode_ff);
   assign f_qv   = fin.q + MW'(f_up);
   assign f_dres = fin.dz ? '0 : (fin.neg ? MW'(0) - f_qv : f_qv);
   assign f_val  = ((fin.func == FUNC_DIV) ? f_dres : fin.res) & mask_mw;
   assign f_sbit = |(f_val & sign_mw);
   assign f_out  = 32'(f_val) | (f_sbit ? ~mask32 : 32'd0);

   logic        rsp_valid_ff;
   logic [31:0] rsp_result_ff;
   logic        rsp_dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_vld_ff[NW];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_result_ff <= f_out;
         rsp_dz_ff     <= (fin.func == FUNC_DIV) & fin.dz;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result   = rsp_result_ff;
   assign rsp_zero_div = rsp_dz_ff;

endmodule

[tb/tb_fixed_point_alu_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_core
// Self-checking bench for the fixed-point ALU: directed corner beats, then
// random beats over several formats and rounding modes, with random request
// gaps, random output stalls and a long output stall.
// ----------------------------------------------------------------------------

class alu_scoreboard;
   int unsigned int_bits;
   int unsigned frac_bits;
   logic [1:0]  round_mode;
   logic [31:0] exp_result[$];
   logic        exp_dz[$];
   int          errors;
   int          checked;

   function new();
      int_bits = 16;
      frac_bits = 16;
      round_mode = fpa_pkg::RND_ZERO;
      errors = 0;
      checked = 0;
   endfunction

   function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == fpa_pkg::REG_INT_BITS) begin
         int_bits = val[5:0];
         if (int_bits < 1) int_bits = 1;
         if (int_bits > 32) int_bits = 32;
      end else if (idx == fpa_pkg::REG_FRAC_BITS) begin
         frac_bits = val[4:0];
      end else if (idx == fpa_pkg::REG_ROUND_MODE) begin
         round_mode = val[1:0];
      end
      if (int_bits + frac_bits > 32) frac_bits = 32 - int_bits;
   endfunction

   function logic [63:0] rounded_quot(logic [63:0] n, logic [63:0] d, bit neg);
      logic [63:0] q;
      logic [63:0] r;
      q = n / d;
      r = n % d;
      if (r != 0) begin
         case (round_mode)
            fpa_pkg::RND_EVEN: if ((r << 1) > d || ((r << 1) == d && q[0])) q++;
            fpa_pkg::RND_POS:  if (!neg) q++;
            fpa_pkg::RND_NEG:  if (neg) q++;
            default: ;
         endcase
      end
      return neg ? 64'd0 - q : q;
   endfunction

   function void note_request(logic [1:0] func, logic [31:0] opa, logic [31:0] opb);
      int unsigned t;
      logic [63:0] m, sgn, a, b, am, bm, r;
      bit an, bn, dz;
      t = int_bits + frac_bits;
      m = (64'd1 << t) - 1;
      sgn = 64'd1 << (t - 1);
      a = {32'd0, opa} & m;
      b = {32'd0, opb} & m;
      an = (a & sgn) != 0;
      bn = (b & sgn) != 0;
      am = an ? (m + 1) - a : a;
      bm = bn ? (m + 1) - b : b;
      dz = 0;
      r = 0;
      case (func)
         fpa_pkg::FUNC_ADD: r = a + b;
         fpa_pkg::FUNC_SUB: r = a - b;
         fpa_pkg::FUNC_MUL: r = rounded_quot(am * bm, 64'd1 << frac_bits, an != bn);
         default: begin
            if (b == 0) dz = 1;
            else r = rounded_quot(am << frac_bits, bm, an != bn);
         end
      endcase
      r &= m;
      if (r & sgn) r |= ~m;
      exp_result.push_back(r[31:0]);
      exp_dz.push_back(dz);
   endfunction

   function void check_result(logic [31:0] res, logic dz);
      logic [31:0] er;
      logic ed;
      checked++;
      if (exp_result.size() == 0) begin
         $display("%0t: unexpected result beat %h dz %b", $time, res, dz);
         errors++;
         return;
      end
      er = exp_result.pop_front();
      ed = exp_dz.pop_front();
      if (res !== er) begin
         $display("%0t: result expected %h actual %h", $time, er, res);
         errors++;
      end
      if (dz !== ed) begin
         $display("%0t: zero_div expected %b actual %b", $time, ed, dz);
         errors++;
      end
   endfunction
endclass

module tb_fixed_point_alu_core;
   import fpa_pkg::*;

   localparam int LATENCY = 70;
   localparam int WATCHDOG = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_func = FUNC_ADD;
   logic [31:0] req_operand_a = '0;
   logic [31:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_result;
   logic rsp_zero_div;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   alu_scoreboard sb = new();
   int idle_cycles = 0;
   int hold_cycles = 0;
   bit rsp_random_stall = 1'b0;
   int sent = 0;

   always #2 clock = ~clock;

   fixed_point_alu_core dut (.*);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_result, rsp_zero_div);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("watchdog expired with %0d results pending", sb.exp_result.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // output stall: long hold when requested, otherwise random if enabled
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (rsp_random_stall) begin
         if ($urandom_range(0, 9) < 7) rsp_stall <= 1'b0;
         else rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx * 4);
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic drain();
      while (sb.exp_result.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_format(int ib, int fb, logic [1:0] rm);
      drain();
      write_reg(REG_INT_BITS, ib);
      write_reg(REG_FRAC_BITS, fb);
      write_reg(REG_ROUND_MODE, {30'd0, rm});
   endtask

   task automatic send(logic [1:0] f, logic [31:0] a, logic [31:0] b, bit gaps);
      int g;
      if (gaps) begin
         g = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
             ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
         if (g > 0) begin
            req_valid <= 1'b0;
            repeat (g) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(f, a, b);
      sent++;
   endtask

   task automatic end_burst();
      req_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000 >> $urandom_range(0, 31);
         3: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int n, bit gaps);
      logic [1:0] f;
      logic [31:0] b;
      repeat (n) begin
         f = 2'($urandom_range(0, 3));
         b = rand_operand();
         send(f, rand_operand(), b, gaps);
      end
      end_burst();
   endtask

   initial begin
      int ib;
      int fb;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset format 16.16
      send(FUNC_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 0);
      send(FUNC_SUB, 32'h8000_0000, 32'h0000_0001, 0);
      send(FUNC_MUL, 32'h0001_8000, 32'hFFFE_8000, 0);
      send(FUNC_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      send(FUNC_DIV, 32'h0001_0000, 32'h0000_0000, 0);
      send(FUNC_DIV, 32'h1234_0000, 32'hABCD_0000, 0);
      send(FUNC_DIV, 32'h8000_0000, 32'hFFFF_0000, 0);
      send(FUNC_DIV, 32'h0001_0000, 32'h0003_0000, 0);
      end_burst();
      for (int rm = 0; rm < 4; rm++) begin
         set_format(28, 3, 2'(rm));
         send(FUNC_MUL, 32'h0000_0003, 32'h0000_0004, 0);
         send(FUNC_MUL, 32'hFFFF_FFFD, 32'h0000_0004, 0);
         send(FUNC_DIV, 32'h0000_0005, 32'hFFFF_FFF2, 0);
         send(FUNC_DIV, 32'hF000_0008, 32'h0000_0000, 0);
         end_burst();
      end
      // clamping cases: int_bits 0 and above max, frac too wide
      set_format(0, 31, RND_EVEN);
      send(FUNC_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 0);
      send(FUNC_DIV, 32'hFFFF_FFFF, 32'h0000_0001, 0);
      end_burst();
      set_format(63, 31, RND_POS);
      send(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 0);
      send(FUNC_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0);
      end_burst();
      set_format(32, 0, RND_NEG);
      send(FUNC_SUB, 32'h0, 32'h8000_0000, 0);
      end_burst();
      set_format(1, 0, RND_ZERO);
      send(FUNC_MUL, 32'h1, 32'h1, 0);
      send(FUNC_DIV, 32'h1, 32'h1, 0);
      end_burst();

      // random over several formats, extremes included
      rsp_random_stall = 1'b1;
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin ib = 16; fb = 16; end
            1: begin ib = 32; fb = 0;  end
            2: begin ib = 1;  fb = 31; end
            3: begin ib = 8;  fb = 8;  end
            default: begin ib = $urandom_range(0, 40); fb = $urandom_range(0, 31); end
         endcase
         rsp_random_stall = 1'b0;
         set_format(ib, fb, 2'($urandom_range(0, 3)));
         rsp_random_stall = 1'b1;
         random_phase(60, ph % 3 != 2);
      end

      // long output hold while beats keep coming
      hold_cycles = 300;
      random_phase(120, 0);
      drain();
      random_phase(30, 1);

      drain();
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d beats, checked %0d results across formats 1..32 bits", sent,
               sb.checked);
      $display("and all four rounding modes, with gaps, stalls and a long output hold.");
      if (sb.errors == 0 && sb.exp_result.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
